// ===== rtl/core/rdir_pkg.sv =====
// shared constants and types of the pinhole camera ray direction block
`timescale 1ns / 1ps
package rdir_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;

  // axis components are signed Q1.14, lengths unsigned Q8.8
  localparam int AXIS_W    = 16;
  localparam int LEN_W     = 16;
  localparam int CFG_W     = 3 * AXIS_W;
  localparam int CFG_IDX_W = 3;
  localparam int DIR_W     = 16;

  // len * num * 256 / (2 * dim) is len * num * 128 / dim
  localparam int OFS_SHIFT = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_DIR,
    REG_RIGHT_AXIS,
    REG_UP_AXIS,
    REG_PLANE_DIST,
    REG_VIEW_W,
    REG_VIEW_H,
    REG_IMAGE_W,
    REG_IMAGE_H
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] VIEW_DIR_RST   = 48'hC000_0000_0000;
  localparam logic [CFG_W-1:0] RIGHT_AXIS_RST = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] UP_AXIS_RST    = 48'h0000_4000_0000;
  localparam logic [LEN_W-1:0] PLANE_DIST_RST = 16'd256;
  localparam logic [LEN_W-1:0] VIEW_W_RST     = 16'd512;
  localparam logic [LEN_W-1:0] VIEW_H_RST     = 16'd384;
  localparam int               IMAGE_W_RST    = 640;
  localparam int               IMAGE_H_RST    = 480;

endpackage

// ===== rtl/core/rdir_if.sv =====
// pixel and ray channel interfaces
`timescale 1ns / 1ps
interface rdir_pix_if #(
  parameter int COORD_BITS = rdir_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rdir_ray_if;
  logic                                valid;
  logic                                ready;
  logic signed [rdir_pkg::DIR_W-1:0]   dir_x;
  logic signed [rdir_pkg::DIR_W-1:0]   dir_y;
  logic signed [rdir_pkg::DIR_W-1:0]   dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== rtl/core/rdir_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rdir_div #(
  parameter int NW = 36,
  parameter int DW = 13,
  parameter int QW = 23
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  // caller guarantees num_i < den_i * 2^QW, so the top part starts below den
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num_i >> QW);
      assign den_in = den_i;
      assign lo_in  = num_i[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    always_comb begin
      trial = {rem_in, lo_in[QW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_q[i] <= den_in;
        lo_q[i]  <= {lo_in[QW-2:0], 1'b0};
        quo_q[i] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== rtl/core/rdir_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module rdir_isqrt #(
  parameter int VW = 62
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [VW-1:0]   val_i,
  output logic [VW/2-1:0] root_o
);

  localparam int STEPS = VW / 2;

  logic [VW-1:0] v_q [STEPS];
  logic [VW-1:0] r_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [VW-1:0] BIT_C = {{(VW-1){1'b0}}, 1'b1} << (VW - 2 - 2 * i);
    logic [VW-1:0] v_in;
    logic [VW-1:0] r_in;
    logic [VW:0]   trial;
    logic [VW-1:0] v_d;
    logic [VW-1:0] r_d;

    if (i == 0) begin : g_first
      assign v_in = val_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
    end

    always_comb begin
      trial = {1'b0, r_in} + {1'b0, BIT_C};
      if ({1'b0, v_in} >= trial) begin
        v_d = v_in - trial[VW-1:0];
        r_d = (r_in >> 1) + BIT_C;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[i] <= v_d;
        r_q[i] <= r_d;
      end
    end
  end

  assign root_o = r_q[STEPS-1][VW/2-1:0];

endmodule

// ===== rtl/core/pinhole_camera_ray_direction_top.sv =====
// top level of the pinhole camera primary ray direction pipeline
`timescale 1ns / 1ps
// Takes one pixel transaction per cycle while pix_i.ready is high and returns
// the unit direction of the ray through the pixel centre, three signed
// components with FRAC_BITS fraction bits, in the order the pixels came in.
// The pipeline depth is set by the two one-bit-per-stage dividers (the
// viewport offset divide and the final normalizing divide) and the 31-stage
// square root, all fully pipelined. Sustained rate is one transaction per
// clock while the output buffer is not full. Results land in a two-entry
// output buffer; pix_i.ready comes straight from the buffer count and drops
// only once that buffer is full, at which point the whole pipeline holds in
// place. Pixels past the image edge clamp to the last row or column, an
// image size of zero counts as one, and a zero direction vector comes out
// as (0,0,0).
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i and must only change while the pipeline is empty.
module pinhole_camera_ray_direction_top #(
  parameter int COORD_BITS = rdir_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rdir_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rdir_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rdir_pkg::CFG_W-1:0]       cfg_data_i,
  rdir_pix_if.sink                         pix_i,
  rdir_ray_if.source                       ray_o
);

  // widths
  localparam int AW     = rdir_pkg::AXIS_W;
  localparam int LW     = rdir_pkg::LEN_W;
  localparam int DIM_W  = COORD_BITS + 1;
  localparam int OPW    = LW + DIM_W;                 // view length times offset
  localparam int ONW    = OPW + rdir_pkg::OFS_SHIFT;  // offset dividend
  localparam int OQW    = LW + rdir_pkg::OFS_SHIFT;   // offset quotient, Q7.16
  localparam int HX_W   = OQW + 1;
  localparam int DQ_W   = LW + 8 + 1;                 // signed dist in Q8.16
  localparam int P_W    = AW + DQ_W;
  localparam int C_W    = P_W + 2;
  localparam int M_W    = C_W - 1;
  localparam int NB     = 30;                         // normalized magnitude bits
  localparam int SQ_W   = 2 * NB;
  localparam int SUM_W  = SQ_W + 2;
  localparam int N_W    = SUM_W / 2;
  localparam int SQS    = N_W;
  localparam int SH_W   = $clog2(M_W - NB + 1);
  localparam int NMW    = NB + FRAC_BITS + 1;
  localparam int DQW    = FRAC_BITS + 1;
  localparam int OW     = rdir_pkg::DIR_W;
  localparam int LAT    = OQW + 10 + SQS + DQW;
  localparam int V_SQ   = OQW + 8 + SQS;
  localparam int DIR_LIM = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][NB-1:0] mag;
  } nrm_t;

  typedef struct packed {
    logic [OW-1:0] x;
    logic [OW-1:0] y;
    logic [OW-1:0] z;
  } ray_t;

  function automatic logic signed [P_W-1:0] smul(logic signed [AW-1:0] a,
                                                 logic signed [DQ_W-1:0] b);
    logic signed [P_W-1:0] ae;
    logic signed [P_W-1:0] be;
    ae = P_W'(a);
    be = P_W'(b);
    return ae * be;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [rdir_pkg::CFG_W-1:0] fwd_q, rgt_q, up_q;
  logic [LW-1:0]              dist_q, vw_q, vh_q;
  logic [DIM_W-1:0]           imw_q, imh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= rdir_pkg::VIEW_DIR_RST;
      rgt_q  <= rdir_pkg::RIGHT_AXIS_RST;
      up_q   <= rdir_pkg::UP_AXIS_RST;
      dist_q <= rdir_pkg::PLANE_DIST_RST;
      vw_q   <= rdir_pkg::VIEW_W_RST;
      vh_q   <= rdir_pkg::VIEW_H_RST;
      imw_q  <= DIM_W'(rdir_pkg::IMAGE_W_RST);
      imh_q  <= DIM_W'(rdir_pkg::IMAGE_H_RST);
    end else if (cfg_we_i) begin
      unique case (rdir_pkg::cfg_reg_e'(cfg_idx_i))
        rdir_pkg::REG_VIEW_DIR:   fwd_q  <= cfg_data_i;
        rdir_pkg::REG_RIGHT_AXIS: rgt_q  <= cfg_data_i;
        rdir_pkg::REG_UP_AXIS:    up_q   <= cfg_data_i;
        rdir_pkg::REG_PLANE_DIST: dist_q <= cfg_data_i[LW-1:0];
        rdir_pkg::REG_VIEW_W:     vw_q   <= cfg_data_i[LW-1:0];
        rdir_pkg::REG_VIEW_H:     vh_q   <= cfg_data_i[LW-1:0];
        rdir_pkg::REG_IMAGE_W:    imw_q  <= cfg_data_i[DIM_W-1:0];
        rdir_pkg::REG_IMAGE_H:    imh_q  <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: one global advance, stops only when the output buffer is full
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_q;
  logic       adv;
  logic       vld_q [LAT];

  assign adv         = (cnt_q != 2'd2);
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pix_i.valid;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: clamp pixel, signed offset numerators 2x+1-W and H-2y-1
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] w_c, h_c, xe, ye, tx, ty, magx_d, magy_d;
  logic             negx_d, negy_d;

  always_comb begin
    w_c = (imw_q == '0) ? DIM_W'(1) : imw_q;
    h_c = (imh_q == '0) ? DIM_W'(1) : imh_q;
    xe  = {1'b0, pix_i.pixel_x};
    ye  = {1'b0, pix_i.pixel_y};
    if (xe >= w_c) xe = w_c - DIM_W'(1);
    if (ye >= h_c) ye = h_c - DIM_W'(1);
    tx  = {xe[DIM_W-2:0], 1'b1};
    ty  = {ye[DIM_W-2:0], 1'b1};
    negx_d = (tx < w_c);
    magx_d = negx_d ? (w_c - tx) : (tx - w_c);
    negy_d = (ty > h_c);
    magy_d = negy_d ? (ty - h_c) : (h_c - ty);
  end

  logic [DIM_W-1:0] magx_a_q, magy_a_q;
  logic [1:0]       neg_a_q, neg_b_q;
  logic [OPW-1:0]   prx_b_q, pry_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      magx_a_q <= magx_d;
      magy_a_q <= magy_d;
      neg_a_q  <= {negy_d, negx_d};
      // stage B: view length times offset numerator
      prx_b_q  <= OPW'(vw_q) * OPW'(magx_a_q);
      pry_b_q  <= OPW'(vh_q) * OPW'(magy_a_q);
      neg_b_q  <= neg_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // offset divide: |len*num|*128 / dim, truncated toward zero
  // ---------------------------------------------------------------------------
  logic [OQW-1:0] qx, qy;
  logic [1:0]     nd_q [OQW];

  rdir_div #(.NW(ONW), .DW(DIM_W), .QW(OQW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({prx_b_q, {rdir_pkg::OFS_SHIFT{1'b0}}}),
    .den_i (w_c),
    .quo_o (qx)
  );

  rdir_div #(.NW(ONW), .DW(DIM_W), .QW(OQW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({pry_b_q, {rdir_pkg::OFS_SHIFT{1'b0}}}),
    .den_i (h_c),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nd_q[0] <= neg_b_q;
      for (int i = 1; i < OQW; i++) nd_q[i] <= nd_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stages C..E: signed offsets, nine products, per-axis sums
  // ---------------------------------------------------------------------------
  logic signed [HX_W-1:0] hx_d, vy_d, hx_q, vy_q;
  logic signed [DQ_W-1:0] dqs;
  logic signed [P_W-1:0]  pf_q [3];
  logic signed [P_W-1:0]  pr_q [3];
  logic signed [P_W-1:0]  pu_q [3];
  logic signed [C_W-1:0]  c_q  [3];

  always_comb begin
    hx_d = $signed({1'b0, qx});
    vy_d = $signed({1'b0, qy});
    if (nd_q[OQW-1][0]) hx_d = -hx_d;
    if (nd_q[OQW-1][1]) vy_d = -vy_d;
    dqs  = $signed({1'b0, dist_q, 8'h00});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hx_q <= hx_d;
      vy_q <= vy_d;
      for (int k = 0; k < 3; k++) begin
        pf_q[k] <= smul($signed(fwd_q[AW*k +: AW]), dqs);
        pr_q[k] <= smul($signed(rgt_q[AW*k +: AW]), DQ_W'(hx_q));
        pu_q[k] <= smul($signed(up_q[AW*k +: AW]), DQ_W'(vy_q));
        c_q[k]  <= C_W'(pf_q[k]) + C_W'(pr_q[k]) + C_W'(pu_q[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages F, G: magnitudes, then common right shift to below 2^30
  // ---------------------------------------------------------------------------
  logic [C_W-1:0]  abs_d [3];
  logic [M_W-1:0]  mag_f_q [3];
  logic [2:0]      neg_f_q;
  logic [M_W-1:0]  orv;
  logic [SH_W-1:0] sh;
  nrm_t            nrm_d, nrm_g_q, nrm_h_q, nrm_i_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_d[k] = c_q[k][C_W-1] ? C_W'(-c_q[k]) : C_W'(c_q[k]);
    end
    orv = mag_f_q[0] | mag_f_q[1] | mag_f_q[2];
    sh  = '0;
    for (int b = NB; b < M_W; b++) begin
      if (orv[b]) sh = SH_W'(b - NB + 1);
    end
    nrm_d.neg = neg_f_q;
    for (int k = 0; k < 3; k++) nrm_d.mag[k] = NB'(mag_f_q[k] >> sh);
  end

  // ---------------------------------------------------------------------------
  // stages H, I: squares and their sum
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]  sq_q [3];
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag_f_q[k] <= abs_d[k][M_W-1:0];
        neg_f_q[k] <= c_q[k][C_W-1];
        sq_q[k]    <= SQ_W'(nrm_g_q.mag[k]) * SQ_W'(nrm_g_q.mag[k]);
      end
      nrm_g_q <= nrm_d;
      nrm_h_q <= nrm_g_q;
      sum_q   <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      nrm_i_q <= nrm_h_q;
    end
  end

  // ---------------------------------------------------------------------------
  // square root of the sum, magnitudes ride alongside
  // ---------------------------------------------------------------------------
  logic [N_W-1:0] root;
  nrm_t           dl_q [SQS];

  rdir_isqrt #(.VW(SUM_W)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .val_i  (sum_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= nrm_i_q;
      for (int i = 1; i < SQS; i++) dl_q[i] <= dl_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage J: rounded dividends, then the normalizing divide
  // ---------------------------------------------------------------------------
  logic [NMW-1:0] num_j_q [3];
  logic [N_W-1:0] n_j_q;
  logic [3:0]     fl_j_q;                 // zero norm, then the three signs
  logic [3:0]     ol_q [DQW];
  logic [DQW-1:0] quo [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        num_j_q[k] <= NMW'({dl_q[SQS-1].mag[k], {FRAC_BITS{1'b0}}}) + NMW'(root >> 1);
      end
      n_j_q   <= root;
      fl_j_q  <= {(root == '0), dl_q[SQS-1].neg};
      ol_q[0] <= fl_j_q;
      for (int i = 1; i < DQW; i++) ol_q[i] <= ol_q[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ndiv
    rdir_div #(.NW(NMW), .DW(N_W), .QW(DQW)) u_div_n (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_j_q[k]),
      .den_i (n_j_q),
      .quo_o (quo[k])
    );
  end

  // final clamp and sign, straight into the output buffer
  logic [OW-1:0] qm [3];
  logic [OW-1:0] dv [3];
  ray_t          ray_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (32'(quo[k]) > 32'd32767) qm[k] = OW'(32767);
      else qm[k] = OW'(quo[k]);
      if (ol_q[DQW-1][3]) dv[k] = '0;
      else if (ol_q[DQW-1][k]) dv[k] = -qm[k];
      else dv[k] = qm[k];
    end
    ray_d = '{x: dv[0], y: dv[1], z: dv[2]};
  end

  // ---------------------------------------------------------------------------
  // two-entry output buffer
  // ---------------------------------------------------------------------------
  ray_t buf_q [2];
  logic wr_q, rd_q;
  logic push, pop;

  assign push = adv && vld_q[LAT-1];
  assign pop  = ray_o.valid && ray_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= ray_d;
  end

  assign ray_o.valid = (cnt_q != 2'd0);
  assign ray_o.dir_x = buf_q[rd_q].x;
  assign ray_o.dir_y = buf_q[rd_q].y;
  assign ray_o.dir_z = buf_q[rd_q].z;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count overflow");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pix_i.ready) |-> $past(ray_o.valid && !ray_o.ready))
    else $error("input stalled without a stalled result");

  a_root_ge_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_SQ] |-> (root >= N_W'(dl_q[SQS-1].mag[0]) &&
                     root >= N_W'(dl_q[SQS-1].mag[1]) &&
                     root >= N_W'(dl_q[SQS-1].mag[2])))
    else $error("square root below a component magnitude");

  a_unit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray_o.valid |-> (ray_o.dir_x <= DIR_LIM && ray_o.dir_x >= -DIR_LIM &&
                     ray_o.dir_y <= DIR_LIM && ray_o.dir_y >= -DIR_LIM &&
                     ray_o.dir_z <= DIR_LIM && ray_o.dir_z >= -DIR_LIM))
    else $error("direction component beyond unit length");

endmodule

// ===== tb/pinhole_camera_ray_direction_top_test.sv =====
// testbench for the pinhole camera ray direction block: directed, random and back-pressure tests
`timescale 1ns / 1ps
module pinhole_camera_ray_direction_top_test;

  // pipeline depth of the top level
  localparam int PIPE_LAT   = 79;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PIX_MAX    = 4095;

  typedef struct {
    logic [rdir_pkg::CFG_W-1:0] fwd;
    logic [rdir_pkg::CFG_W-1:0] right;
    logic [rdir_pkg::CFG_W-1:0] up;
    logic [rdir_pkg::LEN_W-1:0] plane_dist;
    logic [rdir_pkg::LEN_W-1:0] vw;
    logic [rdir_pkg::LEN_W-1:0] vh;
    logic [12:0]                img_w;
    logic [12:0]                img_h;
  } camera_t;

  typedef struct {
    logic signed [rdir_pkg::DIR_W-1:0] dx;
    logic signed [rdir_pkg::DIR_W-1:0] dy;
    logic signed [rdir_pkg::DIR_W-1:0] dz;
  } ray_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [rdir_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [rdir_pkg::CFG_W-1:0]     cfg_data_i = '0;

  rdir_pix_if #(.COORD_BITS(rdir_pkg::COORD_BITS_DEF)) pix ();
  rdir_ray_if ray ();

  pinhole_camera_ray_direction_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .ray_o      (ray)
  );

  // camera settings as the block currently holds them
  camera_t cam;
  // expected directions, oldest first
  ray_t    pending_rays[$];

  int  mismatches = 0;
  int  rays_checked = 0;
  int  pixels_sent = 0;
  int  cam_loads = 0;
  longint cycle_cnt = 0;

  // sender and receiver behavior knobs
  bit  tx_no_gaps = 1'b0;
  bit  rx_free = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_stall_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    pix.valid   = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    ray.ready   = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d rays outstanding", cycle_cnt,
               pending_rays.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ray.ready <= 1'b0;
    end else if (rx_free) begin
      ray.ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      ray.ready <= 1'b0;
    end else begin
      rx_stall_left = pick_gap();
      ray.ready <= (rx_stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // direction predictor

  // len * num * 256 / den with the magnitude rounded toward zero
  function automatic longint viewport_offset(longint len, longint num, longint den);
    longint q;
    q = (len * (num < 0 ? -num : num) * 256) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
    longint w, h, x, y, hx, vy, dq, c, m, sum, n, q;
    longint mag[3];
    longint fa, ra, ua;
    bit     neg[3];
    logic [rdir_pkg::DIR_W-1:0] o[3];
    int     s;
    ray_t   r;
    w = (cam.img_w == 0) ? 1 : longint'(cam.img_w);
    h = (cam.img_h == 0) ? 1 : longint'(cam.img_h);
    x = longint'(px);
    y = longint'(py);
    // clamp pixels past the image edge
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    hx = viewport_offset(longint'(cam.vw), 2 * x + 1 - w, 2 * w);
    vy = viewport_offset(longint'(cam.vh), h - 2 * y - 1, 2 * h);
    dq = longint'(cam.plane_dist) * 256;
    m  = 0;
    for (int k = 0; k < 3; k++) begin
      fa = longint'($signed(cam.fwd[16*k +: 16]));
      ra = longint'($signed(cam.right[16*k +: 16]));
      ua = longint'($signed(cam.up[16*k +: 16]));
      c  = fa * dq + ra * hx + ua * vy;
      neg[k] = c < 0;
      mag[k] = neg[k] ? -c : c;
      if (mag[k] > m) m = mag[k];
    end
    // bring the largest component under 2^30 before squaring
    s = 0;
    while ((m >> s) >= (longint'(1) << 30)) s++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = mag[k] >> s;
      sum = sum + mag[k] * mag[k];
    end
    n = floor_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = 0;
      if (n != 0) begin
        q = ((mag[k] << 14) + n / 2) / n;
        if (q > 32767) q = 32767;
      end
      o[k] = neg[k] ? rdir_pkg::DIR_W'(-q) : rdir_pkg::DIR_W'(q);
    end
    r.dx = o[0];
    r.dy = o[1];
    r.dz = o[2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker

  always @(posedge clk_i) begin
    ray_t exp_ray;
    if (rst_ni && ray.valid && ray.ready) begin
      if (pending_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected ray transaction (%0d,%0d,%0d)", ray.dir_x, ray.dir_y,
                   ray.dir_z);
      end else begin
        exp_ray = pending_rays.pop_front();
        rays_checked++;
        if (ray.dir_x !== exp_ray.dx || ray.dir_y !== exp_ray.dy ||
            ray.dir_z !== exp_ray.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ray %0d mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     rays_checked, exp_ray.dx, exp_ray.dy, exp_ray.dz,
                     ray.dir_x, ray.dir_y, ray.dir_z);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared tasks

  // offer one pixel and wait for its transaction; caller sits just after an edge
  task automatic send_pixel(int px, int py);
    int gap;
    pix.valid   <= 1'b1;
    pix.pixel_x <= 12'(px);
    pix.pixel_y <= 12'(py);
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pending_rays.push_back(predict_ray(12'(px), 12'(py)));
    pixels_sent++;
    gap = tx_no_gaps ? 0 : pick_gap();
    // keep valid high across back-to-back pixels
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    pix.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering pixels, then wait for every outstanding ray
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // writes all eight registers in a row; only called with the pipeline empty
  task automatic load_camera(camera_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rdir_pkg::REG_VIEW_DIR;   cfg_data_i <= c.fwd;   @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_RIGHT_AXIS; cfg_data_i <= c.right; @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_UP_AXIS;    cfg_data_i <= c.up;    @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_PLANE_DIST;
    cfg_data_i <= rdir_pkg::CFG_W'(c.plane_dist);
    @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_VIEW_W;  cfg_data_i <= rdir_pkg::CFG_W'(c.vw);
    @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_VIEW_H;  cfg_data_i <= rdir_pkg::CFG_W'(c.vh);
    @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_IMAGE_W; cfg_data_i <= rdir_pkg::CFG_W'(c.img_w);
    @(posedge clk_i);
    cfg_idx_i <= rdir_pkg::REG_IMAGE_H; cfg_data_i <= rdir_pkg::CFG_W'(c.img_h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cam = c;
    cam_loads++;
  endtask

  function automatic camera_t default_camera();
    camera_t c;
    c.fwd        = rdir_pkg::VIEW_DIR_RST;
    c.right      = rdir_pkg::RIGHT_AXIS_RST;
    c.up         = rdir_pkg::UP_AXIS_RST;
    c.plane_dist = rdir_pkg::PLANE_DIST_RST;
    c.vw         = rdir_pkg::VIEW_W_RST;
    c.vh         = rdir_pkg::VIEW_H_RST;
    c.img_w      = 13'(rdir_pkg::IMAGE_W_RST);
    c.img_h      = 13'(rdir_pkg::IMAGE_H_RST);
    return c;
  endfunction

  function automatic logic [rdir_pkg::CFG_W-1:0] random_axis();
    logic [rdir_pkg::CFG_W-1:0] a;
    if ($urandom_range(0, 3) == 0) begin
      a = rdir_pkg::CFG_W'({$urandom(), $urandom()});
    end else begin
      // moderate components, signs at random
      for (int k = 0; k < 3; k++) a[16*k +: 16] = 16'($signed($urandom_range(0, 32768)) -
                                                      16384);
    end
    return a;
  endfunction

  function automatic camera_t random_camera();
    camera_t c;
    c.fwd        = random_axis();
    c.right      = random_axis();
    c.up         = random_axis();
    c.plane_dist = 16'($urandom_range(1, 65535));
    c.vw         = 16'($urandom_range(1, 65535));
    c.vh         = 16'($urandom_range(1, 65535));
    c.img_w = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(1, 4096))
                                          : 13'($urandom_range(1, 256));
    c.img_h = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(1, 4096))
                                          : 13'($urandom_range(1, 256));
    return c;
  endfunction

  // mostly pixels inside the image, some anywhere in the field
  task automatic send_random_pixel();
    int w, h;
    w = (cam.img_w == 0) ? 1 : cam.img_w;
    h = (cam.img_h == 0) ? 1 : cam.img_h;
    if ($urandom_range(0, 3) == 0)
      send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
    else
      send_pixel($urandom_range(0, (w > 4096 ? 4096 : w) - 1),
                 $urandom_range(0, (h > 4096 ? 4096 : h) - 1));
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // reset values: corners, centre and clamped pixels
  task automatic test_reset_camera();
    cam = default_camera();
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(640, 0);
    wait_drained();
  endtask

  // extreme register values and the named corner cases
  task automatic test_extremes();
    camera_t c;
    // full 4096 image, lengths at maximum, every pixel bit toggled
    c = default_camera();
    c.plane_dist = 16'hFFFF; c.vw = 16'hFFFF; c.vh = 16'hFFFF;
    c.img_w = 13'd4096; c.img_h = 13'd4096;
    load_camera(c);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    wait_drained();
    // minimum lengths, one pixel image
    c.plane_dist = 16'd1; c.vw = 16'd1; c.vh = 16'd1;
    c.img_w = 13'd1; c.img_h = 13'd1;
    load_camera(c);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    wait_drained();
    // zero image size counts as one, widest raw size
    c = default_camera();
    c.img_w = 13'd0; c.img_h = 13'h1FFF;
    load_camera(c);
    send_pixel(5, 4000);
    send_pixel(0, 0);
    wait_drained();
    // zero direction vector
    c.fwd = '0; c.right = '0; c.up = '0;
    load_camera(c);
    send_pixel(10, 10);
    wait_drained();
    // most negative axis components, all-ones packing
    c = default_camera();
    c.fwd = 48'h8000_8000_8000; c.right = 48'hFFFF_FFFF_FFFF; c.up = 48'h7FFF_7FFF_7FFF;
    c.plane_dist = 16'hFFFF;
    load_camera(c);
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(100, 300);
    wait_drained();
  endtask

  // the default and then random camera settings, each with a burst of random pixels
  task automatic test_random_cameras();
    int burst;
    for (int ph = 0; ph < 8; ph++) begin
      load_camera(ph == 0 ? default_camera() : random_camera());
      // a stretch with no idling on either side in some phases
      tx_no_gaps = (ph % 3 == 1);
      rx_free    = (ph % 3 == 1);
      burst = 170;
      repeat (burst) send_random_pixel();
      idle_sender();
      wait_drained();
    end
    tx_no_gaps = 1'b0;
    rx_free    = 1'b0;
  endtask

  // receiver holds off while pixels keep coming, so the pipeline fills
  task automatic test_backpressure();
    load_camera(random_camera());
    tx_no_gaps = 1'b1;
    hold_req   = 1'b1;
    repeat (150) send_random_pixel();
    tx_no_gaps = 1'b0;
    idle_sender();
    wait_drained();
  endtask

  // sender pauses until every ray is back, then resumes
  task automatic test_pause_and_resume();
    load_camera(default_camera());
    repeat (40) send_random_pixel();
    idle_sender();
    wait_drained();
    repeat (40) send_random_pixel();
    idle_sender();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_camera();
    test_extremes();
    test_random_cameras();
    test_backpressure();
    test_pause_and_resume();

    idle_sender();
    wait_drained();
    repeat (PIPE_LAT + 20) @(posedge clk_i);

    $display("sent %0d pixels over %0d camera settings, checked %0d rays, %0d mismatches",
             pixels_sent, cam_loads + 1, rays_checked, mismatches);
    $display("covered clamping, zero sizes, zero vector, extreme lengths and back-pressure");
    if (mismatches == 0 && pending_rays.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
